@@ hw/rtl/hrcd_pkg.sv @@
// shared types and constants for the http response completion detector
`timescale 1ns / 1ps
`default_nettype none

package hrcd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int KEY_LEN    = 14;
  localparam int LEN_BITS   = 64;
  localparam int HDR_BITS   = 32;
  localparam int OUT_BITS   = 2 + HDR_BITS + LEN_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [23:0] CR_LF_CR = {CH_CR, CH_LF, CH_CR};

  localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic                complete;
    logic                header_done;
    logic [HDR_BITS-1:0] header_bytes;
    logic [LEN_BITS-1:0] body_length;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/hrcd_track.sv @@
// per-response tracking state and the single-pass update for one byte
`timescale 1ns / 1ps
`default_nettype none

module hrcd_track (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire hrcd_pkg::item_t item,
  output hrcd_pkg::result_t    res
);
  import hrcd_pkg::*;

  typedef enum logic [2:0] {PH_KEY, PH_COLON, PH_SPACE, PH_DIGITS, PH_DONE} phase_t;
  typedef enum logic [1:0] {ST_NONE, ST_VALID, ST_OVER} status_t;

  logic [23:0]           recent_bytes, recent_bytes_next;
  logic [COUNT_BITS-1:0] bytes_seen, bytes_seen_next;
  logic                  blank_line_seen, blank_line_seen_next;
  logic [COUNT_BITS-1:0] header_end_count, header_end_count_next;
  logic [3:0]            key_progress, key_progress_next;
  phase_t                field_phase, field_phase_next;
  logic [LEN_BITS-1:0]   length_value, length_value_next;
  status_t               length_status, length_status_next;

  logic [23:0]           rb;
  logic [COUNT_BITS-1:0] bs, hend;
  logic                  blank;
  logic [3:0]            kp;
  phase_t                ph;
  logic [LEN_BITS-1:0]   lv;
  status_t               ls;
  logic [7:0]            b, folded;
  logic                  is_digit;
  logic [LEN_BITS+3:0]   scaled;
  logic [LEN_BITS-1:0]   body;
  logic [COUNT_BITS-1:0] body_span;

  always_comb begin
    b        = item.data_byte;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    folded   = (b inside {[CH_UP_A:CH_UP_Z]}) ? b + CASE_GAP : b;
    scaled   = ({4'b0, lv} << 3) + ({4'b0, lv} << 1) + (LEN_BITS + 4)'(b - CH_ZERO);
  end

  // a new response starts from the reset state
  always_comb begin
    if (item.first_byte) begin
      rb    = '0;
      bs    = '0;
      blank = 1'b0;
      hend  = '0;
      kp    = '0;
      ph    = PH_KEY;
      lv    = '0;
      ls    = ST_NONE;
    end else begin
      rb    = recent_bytes;
      bs    = bytes_seen;
      blank = blank_line_seen;
      hend  = header_end_count;
      kp    = key_progress;
      ph    = field_phase;
      lv    = length_value;
      ls    = length_status;
    end
  end

  always_comb begin
    bytes_seen_next       = (bs != COUNT_MAX) ? bs + 1'b1 : bs;
    blank_line_seen_next  = blank;
    header_end_count_next = hend;
    if (!blank && rb == CR_LF_CR && b == CH_LF) begin
      blank_line_seen_next  = 1'b1;
      header_end_count_next = bytes_seen_next;
    end
    recent_bytes_next = {rb[15:0], b};

    key_progress_next  = kp;
    field_phase_next   = ph;
    length_value_next  = lv;
    length_status_next = ls;

    case (ph)
      PH_KEY: begin
        if (kp < 4'(KEY_LEN) && folded == KEY_CHARS[kp]) begin
          key_progress_next = kp + 1'b1;
        end else begin
          key_progress_next = (folded == KEY_CHARS[0]) ? 4'd1 : 4'd0;
        end
        if (key_progress_next >= 4'(KEY_LEN)) begin
          field_phase_next = PH_COLON;
        end
      end
      PH_COLON: begin
        if (b == CH_COLON) begin
          field_phase_next = PH_SPACE;
        end
      end
      PH_SPACE, PH_DIGITS: begin
        if (is_digit) begin
          field_phase_next = PH_DIGITS;
          if (ls != ST_OVER) begin
            if (scaled[LEN_BITS+3:LEN_BITS] != 4'd0) begin
              length_status_next = ST_OVER;
              length_value_next  = '0;
            end else begin
              length_status_next = ST_VALID;
              length_value_next  = scaled[LEN_BITS-1:0];
            end
          end
        end else if (!(ph == PH_SPACE && b == CH_SPACE)) begin
          field_phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    body = (field_phase_next == PH_DONE && length_status_next == ST_VALID) ?
           length_value_next : '0;
    body_span = bytes_seen_next - header_end_count_next;

    res.complete     = blank_line_seen_next && (LEN_BITS'(body_span) >= body);
    res.header_done  = blank_line_seen_next;
    res.header_bytes = blank_line_seen_next ? HDR_BITS'(header_end_count_next) : '0;
    res.body_length  = body;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes     <= '0;
      bytes_seen       <= '0;
      blank_line_seen  <= 1'b0;
      header_end_count <= '0;
      key_progress     <= '0;
      field_phase      <= PH_KEY;
      length_value     <= '0;
      length_status    <= ST_NONE;
    end else if (take) begin
      recent_bytes     <= recent_bytes_next;
      bytes_seen       <= bytes_seen_next;
      blank_line_seen  <= blank_line_seen_next;
      header_end_count <= header_end_count_next;
      key_progress     <= key_progress_next;
      field_phase      <= field_phase_next;
      length_value     <= length_value_next;
      length_status    <= length_status_next;
    end
  end

`ifndef SYNTHESIS
  a_complete_needs_header: assert property (@(posedge clk) disable iff (rst)
    res.complete |-> res.header_done)
    else $error("complete without header end");

  a_header_end_bounded: assert property (@(posedge clk) disable iff (rst)
    blank_line_seen |-> (header_end_count != '0) && (header_end_count <= bytes_seen))
    else $error("header end count out of range");

  a_blank_sticky: assert property (@(posedge clk) disable iff (rst)
    take && !item.first_byte && blank_line_seen |=> blank_line_seen)
    else $error("header end lost within a response");

  a_overflow_clears: assert property (@(posedge clk) disable iff (rst)
    length_status == ST_OVER |-> length_value == '0)
    else $error("overflowed length holds a value");

  a_body_only_when_done: assert property (@(posedge clk) disable iff (rst)
    res.body_length != '0 |-> field_phase_next == PH_DONE)
    else $error("body length reported before value ended");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/http_response_completion_detector.sv @@
// top level: input stage, byte tracker and result register
`timescale 1ns / 1ps
`default_nettype none

// Content-Length framing detector for an HTTP response byte stream.
// s_axis carries one response byte per transaction; tuser set marks the
// first byte of a new response and clears all tracking state before that
// byte is taken. m_axis returns one result per input byte, in order:
// complete, header_done, header_bytes and the effective body length.
// An accepted byte is held in the input register, and the single-pass
// update then loads its result into the result register, which drives
// m_axis. One transaction is taken every cycle while the output side
// keeps up.
// When m_axis stalls, the result register holds its transaction and the
// input register still takes one byte if it is empty, then s_axis_tready
// drops until the result is taken. Reset (synchronous, active high) empties
// both registers and returns the tracker to its start-of-response state.
module http_response_completion_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // data_byte
  input  wire logic                            s_axis_tuser,  // first_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // complete, header_done, header_bytes, body_length, zero padding
  output logic [hrcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import hrcd_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  hrcd_track u_track (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.data_byte  <= s_axis_tdata;
      in_item.first_byte <= s_axis_tuser;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_res.body_length,
                          out_res.header_bytes, out_res.header_done, out_res.complete};

`ifndef SYNTHESIS
  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready && !advance |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  a_no_drop_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both stages full");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the http response completion detector
`timescale 1ns / 1ps

module tb;
  import hrcd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    FIND_KEY, FIND_COLON, SKIP_SPACES, IN_DIGITS, VALUE_FINAL
  } field_step_e;

  typedef enum logic [1:0] {
    NO_DIGITS, LEN_VALID, LEN_OVERFLOW
  } len_state_e;

  class completion_scoreboard;
    result_t             expected_q[$];
    logic [23:0]         last_three;
    logic [COUNT_BITS-1:0] byte_count;
    logic                hdr_seen;
    logic [COUNT_BITS-1:0] hdr_len;
    int unsigned         key_pos;
    field_step_e         field_step;
    logic [LEN_BITS-1:0] len_val;
    len_state_e          len_state;
    int unsigned         failures;
    int unsigned         results_seen;
    int unsigned         completes_seen;

    function new();
      clear_response();
      failures = 0;
      results_seen = 0;
      completes_seen = 0;
    endfunction

    function void clear_response();
      last_three = '0;
      byte_count = '0;
      hdr_seen   = 1'b0;
      hdr_len    = '0;
      key_pos    = 0;
      field_step = FIND_KEY;
      len_val    = '0;
      len_state  = NO_DIGITS;
    endfunction

    function void take_digit(logic [7:0] b);
      logic [LEN_BITS-1:0] d;
      d = {56'd0, b - CH_ZERO};
      if (len_state == LEN_OVERFLOW) return;
      if (len_val > ({LEN_BITS{1'b1}} - d) / 64'd10) begin
        len_state = LEN_OVERFLOW;
        len_val = '0;
      end else begin
        len_val = len_val * 64'd10 + d;
        len_state = LEN_VALID;
      end
    endfunction

    // one accepted input transaction: advance the tracker, queue its result
    function void note_input(logic [7:0] b, logic first);
      logic [7:0]          lc;
      logic                is_digit;
      logic [LEN_BITS-1:0] body;
      result_t             r;
      if (first) clear_response();
      if (byte_count != COUNT_MAX) byte_count++;
      if (!hdr_seen && last_three == CR_LF_CR && b == CH_LF) begin
        hdr_seen = 1'b1;
        hdr_len = byte_count;
      end
      last_three = {last_three[15:0], b};
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      case (field_step)
        FIND_KEY: begin
          lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
          if (key_pos < KEY_LEN && lc == KEY_CHARS[key_pos]) key_pos++;
          else key_pos = (lc == KEY_CHARS[0]) ? 1 : 0;
          if (key_pos >= KEY_LEN) field_step = FIND_COLON;
        end
        FIND_COLON: begin
          if (b == CH_COLON) field_step = SKIP_SPACES;
        end
        SKIP_SPACES: begin
          if (b != CH_SPACE) begin
            if (is_digit) begin
              take_digit(b);
              field_step = IN_DIGITS;
            end else begin
              field_step = VALUE_FINAL;
            end
          end
        end
        IN_DIGITS: begin
          if (is_digit) take_digit(b);
          else field_step = VALUE_FINAL;
        end
        default: ;
      endcase
      body = (field_step == VALUE_FINAL && len_state == LEN_VALID) ? len_val : '0;
      r.complete     = hdr_seen && ({32'd0, byte_count - hdr_len} >= body);
      r.header_done  = hdr_seen;
      r.header_bytes = hdr_seen ? hdr_len[HDR_BITS-1:0] : '0;
      r.body_length  = body;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      result_t    exp_r;
      logic [OUT_DATA_W-OUT_BITS-1:0] pad;
      logic       got_c, got_h;
      logic [HDR_BITS-1:0] got_hdr;
      logic [LEN_BITS-1:0] got_len;
      got_c   = data[0];
      got_h   = data[1];
      got_hdr = data[2 +: HDR_BITS];
      got_len = data[2 + HDR_BITS +: LEN_BITS];
      pad     = data[OUT_DATA_W-1:OUT_BITS];
      results_seen++;
      if (got_c) completes_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result transaction: c=%0b h=%0b hdr=%0d len=%0d",
                   got_c, got_h, got_hdr, got_len);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_c !== exp_r.complete || got_h !== exp_r.header_done ||
          got_hdr !== exp_r.header_bytes || got_len !== exp_r.body_length ||
          pad !== '0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result %0d mismatch: exp c=%0b h=%0b hdr=%0d len=%0d pad=0",
                   results_seen, exp_r.complete, exp_r.header_done,
                   exp_r.header_bytes, exp_r.body_length);
          $display("  got c=%0b h=%0b hdr=%0d len=%0d pad=%0h",
                   got_c, got_h, got_hdr, got_len, pad);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // data_byte
  logic s_axis_tuser = 1'b0;         // first_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // complete, header_done, header_bytes, body_length, zero padding
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  completion_scoreboard sb = new();

  logic [7:0]  msg_q[$];
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned holds_done = 0;
  int unsigned bytes_sent = 0;
  int unsigned responses_sent = 0;
  int unsigned idle_cycles = 0;

  http_response_completion_detector u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(b, first);
    bytes_sent++;
  endtask

  task automatic send_msg(input logic first);
    foreach (msg_q[i]) send_byte(msg_q[i], (i == 0) ? first : 1'b0);
    msg_q.delete();
    responses_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  // key characters from index lo up to hi-1, letters in random case
  function automatic void push_key(int lo, int hi);
    logic [7:0] c;
    for (int i = lo; i < hi; i++) begin
      c = KEY_CHARS[i];
      if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - CASE_GAP;
      msg_q.push_back(c);
    end
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_response();
    int unsigned kind, vkind, value, n, cut;
    int          delta;
    bit          small_value;
    small_value = 1'b0;
    value = 0;
    if ($urandom_range(9) == 0) begin
      push_random($urandom_range(1, 30));
      return;
    end
    case ($urandom_range(2))
      0: push_text("HTTP/1.1 200 OK\r\n");
      1: push_text("H\r\n");
      default: ;
    endcase
    kind = $urandom_range(9);
    case (kind)
      0: push_text("Server: x\r\n");
      1: begin
        // interrupted key, then the key again
        push_key(0, $urandom_range(1, KEY_LEN - 1));
        if ($urandom_range(1) == 1) begin
          msg_q.push_back("c");
          push_key(1, KEY_LEN);
        end else begin
          msg_q.push_back("x");
          push_key(0, KEY_LEN);
        end
      end
      2: begin
        push_text("cc");
        push_key(0, KEY_LEN);
      end
      default: push_key(0, KEY_LEN);
    endcase
    if (kind != 0 && kind != 3) begin
      if ($urandom_range(7) == 0) push_text("\tx");
      if (kind == 4) begin
        // no colon on this line; a later header supplies one
        push_text("\r\nHost: ");
      end else begin
        msg_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 3)) msg_q.push_back(CH_SPACE);
      end
      vkind = $urandom_range(11);
      case (vkind)
        0: push_text("x");
        1: begin
          push_text("18446744073709551616");
          repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        2: push_text("18446744073709551615");
        3: push_text("999999999999999999999");
        4: repeat ($urandom_range(5, 19))
             msg_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        5: begin
          value = $urandom_range(0, 40);
          push_text($sformatf("00%0d", value));
          small_value = 1'b1;
        end
        default: begin
          value = $urandom_range(0, 50);
          push_text($sformatf("%0d", value));
          small_value = 1'b1;
        end
      endcase
    end
    push_text("\r\n");
    if ($urandom_range(3) == 0) push_text("content-length: 7\r\n");
    if ($urandom_range(2) == 0) push_text("X-A: b\r\n");
    case ($urandom_range(9))
      0: ;
      1: push_text("\r\n\rx\r\n\r\n");
      default: push_text("\r\n");
    endcase
    if (kind == 3) push_text($sformatf("Content-Length: %0d ", $urandom_range(0, 9)));
    if (small_value && kind != 4) begin
      delta = int'($urandom_range(0, 5)) - 2;
      n = (int'(value) + delta < 0) ? 0 : value + delta;
    end else begin
      n = $urandom_range(0, 8);
    end
    push_random(n);
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : ready_pattern
    int unsigned mode, left, tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(50, 300);
      end
      left--;
      tick++;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(1));
        2: m_axis_tready <= (tick % 7) >= 3;
        default: m_axis_tready <= ($urandom_range(4) == 0);
      endcase
    end
  end

  initial begin : stimulus
    bit hold_issued, pause_done;
    hold_issued = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // byte extremes, bare header end, then a short complete response
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    push_text("\r\n\r\n");
    send_msg(1'b1);
    push_text("CONTENT-LENGTH:1\r\n\r\nz");
    send_msg(1'b1);
    drain_results();

    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(15) == 0) sender_steady = ~sender_steady;
      build_response();
      send_msg($urandom_range(19) != 0);
      if (!hold_issued && bytes_sent > 600) begin
        hold_issued = 1'b1;
        hold_req = 1'b1;
      end
      if (!pause_done && bytes_sent > 1000) begin
        pause_done = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d responses, %0d bytes, %0d results (%0d complete), %0d long stalls",
             responses_sent, bytes_sent, sb.results_seen, sb.completes_seen, holds_done);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failing results", sb.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
